// ===== design/radix_converter_signed_fraction_macros.svh =====
// Assertion macros for the radix converter
`ifndef RADIX_CONVERTER_SIGNED_FRACTION_MACROS_SVH
`define RADIX_CONVERTER_SIGNED_FRACTION_MACROS_SVH
// implication checked on every clock, off during reset
`define RCSF_ASSERT_IMP(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) else $error(msg);
// implication, right side checked on the clock after the left side holds
`define RCSF_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== design/rcsf_pkg.sv =====
package rcsf_pkg;

  localparam int unsigned CharW = 8;
  localparam int unsigned BaseW = 5;
  localparam int unsigned IdxW = 1;

  localparam logic [IdxW-1:0] RegSrcBase = 1'd0;
  localparam logic [IdxW-1:0] RegTgtBase = 1'd1;

  localparam logic [BaseW-1:0] BaseReset = 5'd10;

  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChPoint = 8'h2E;
  localparam logic [CharW-1:0] ChZero = 8'h30;

  typedef struct packed {
    logic [CharW-1:0] in_char;
    logic             in_last;
  } in_item_t;

  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             out_error;
    logic             out_last;
  } out_item_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_FDIV,
    BK_CHECK,
    BK_SIGN,
    BK_IDIV,
    BK_IOUT,
    BK_POINT,
    BK_FMUL,
    BK_FOUT,
    BK_ERR
  } bk_state_e;

  function automatic logic [4:0] digit_of(input logic [CharW-1:0] c);
    logic [4:0] d;
    d = 5'h1F;
    if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
    else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
    return d;
  endfunction

  function automatic logic [CharW-1:0] glyph(input logic [3:0] d);
    return (d < 4'd10) ? 8'(8'h30 + d) : 8'(8'h41 + d - 4'd10);
  endfunction

  function automatic logic base_ok(input logic [BaseW-1:0] b);
    return b >= 5'd2 && b <= 5'd16;
  endfunction

endpackage

// ===== design/rcsf_front.sv =====
module rcsf_front #(
  parameter int unsigned INT_BITS    = 48,
  parameter int unsigned MAX_FRAC_IN = 12
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  rcsf_pkg::in_item_t         item_i,
  input  logic [rcsf_pkg::BaseW-1:0] src_base_i,
  input  logic                       full_i,
  output logic                       push_o,
  output logic [INT_BITS-1:0]        int_o,
  output logic [4*MAX_FRAC_IN+1-1:0] numer_o,
  output logic [4*MAX_FRAC_IN+1-1:0] denom_o,
  output logic                       neg_o,
  output logic                       err_o
);
  import rcsf_pkg::*;

  localparam int unsigned FW = 4 * MAX_FRAC_IN + 1;
  localparam int unsigned CW = $clog2(MAX_FRAC_IN + 1);

  logic [INT_BITS-1:0] int_q, int_d;
  logic [FW-1:0]       numer_q, numer_d, denom_q, denom_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                neg_q, neg_d, pt_q, pt_d, start_q, start_d, bad_q, bad_d;
  logic                lone;
  logic [4:0]          dg;
  logic [INT_BITS+4:0] iv;
  logic                take;

  assign take = valid_i && !full_i;
  assign dg = digit_of(item_i.in_char);
  assign iv = (INT_BITS+5)'(int_q) * (INT_BITS+5)'(src_base_i)
            + (INT_BITS+5)'(dg[3:0]);

  always_comb begin
    int_d = int_q; numer_d = numer_q; denom_d = denom_q; cnt_d = cnt_q;
    neg_d = neg_q; pt_d = pt_q; start_d = start_q; bad_d = bad_q;
    lone = start_q && item_i.in_char == ChMinus && item_i.in_last;
    if (start_q && item_i.in_char == ChMinus) begin
      neg_d = 1'b1; start_d = 1'b0;
    end else begin
      start_d = 1'b0;
      if (item_i.in_char == ChPoint) begin
        if (pt_q) bad_d = 1'b1;
        pt_d = 1'b1;
      end else if (dg == 5'h1F || !base_ok(src_base_i) || dg >= src_base_i) begin
        bad_d = 1'b1;
      end else if (!bad_q) begin
        if (!pt_q) begin
          if (iv[INT_BITS+4:INT_BITS] != '0) bad_d = 1'b1;
          else int_d = iv[INT_BITS-1:0];
        end else if (cnt_q < CW'(MAX_FRAC_IN)) begin
          numer_d = FW'(numer_q * src_base_i) + FW'(dg[3:0]);
          denom_d = FW'(denom_q * src_base_i);
          cnt_d = cnt_q + 1'b1;
        end
      end
    end
  end

  assign push_o  = take && item_i.in_last;
  assign int_o   = int_d;
  assign numer_o = numer_d;
  assign denom_o = denom_d;
  assign neg_o   = neg_d;
  assign err_o   = lone || bad_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      int_q <= '0; numer_q <= '0; denom_q <= FW'(1); cnt_q <= '0;
      neg_q <= 1'b0; pt_q <= 1'b0; start_q <= 1'b1; bad_q <= 1'b0;
    end else if (take) begin
      if (item_i.in_last) begin
        int_q <= '0; numer_q <= '0; denom_q <= FW'(1); cnt_q <= '0;
        neg_q <= 1'b0; pt_q <= 1'b0; start_q <= 1'b1; bad_q <= 1'b0;
      end else begin
        int_q <= int_d; numer_q <= numer_d; denom_q <= denom_d; cnt_q <= cnt_d;
        neg_q <= neg_d; pt_q <= pt_d; start_q <= start_d; bad_q <= bad_d;
      end
    end
  end
endmodule

// ===== design/rcsf_queue.sv =====
module rcsf_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i && !full_o) - 2'(pop_i && !empty_o);
    end
  end
endmodule

// ===== design/rcsf_back.sv =====
module rcsf_back #(
  parameter int unsigned INT_BITS     = 48,
  parameter int unsigned MAX_FRAC_IN  = 12,
  parameter int unsigned FRAC_BITS    = 40,
  parameter int unsigned MAX_FRAC_OUT = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       empty_i,
  output logic                       pop_o,
  input  logic [INT_BITS-1:0]        int_i,
  input  logic [4*MAX_FRAC_IN+1-1:0] numer_i,
  input  logic [4*MAX_FRAC_IN+1-1:0] denom_i,
  input  logic                       neg_i,
  input  logic                       err_i,
  input  logic [rcsf_pkg::BaseW-1:0] src_base_i,
  input  logic [rcsf_pkg::BaseW-1:0] tgt_base_i,
  output logic                       valid_o,
  output rcsf_pkg::out_item_t        item_o,
  input  logic                       ready_i
);
  import rcsf_pkg::*;

  localparam int unsigned FW = 4 * MAX_FRAC_IN + 1;
  localparam int unsigned IW = $clog2(INT_BITS + 1);
  localparam int unsigned BW = $clog2(INT_BITS);
  localparam int unsigned KW = $clog2(MAX_FRAC_OUT + 1);
  localparam int unsigned SW = $clog2(FRAC_BITS + 1);
  localparam int unsigned QW = $clog2(INT_BITS + 1);
  localparam logic [FRAC_BITS-1:0] Eps = FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd10000000000);

  bk_state_e state_q, state_d;
  logic [INT_BITS-1:0]  v_q, quo_q, rem_acc_q;
  logic [FW:0]          r_q, den_q;
  logic [FRAC_BITS-1:0] f_q;
  logic [SW-1:0]        step_q;
  logic [QW-1:0]        bit_q;
  logic [IW-1:0]        nd_q;
  logic [KW-1:0]        k_q;
  logic                 neg_q;
  logic                 zero_q;
  logic [3:0]           buf_q [INT_BITS];
  logic [3:0]           buf_rd_q;
  logic [FRAC_BITS+4:0] fm;
  logic                 fire, wr_buf, zero_val;
  logic [INT_BITS:0]    rem_sh;
  logic [INT_BITS:0]    tb_ext;
  logic                 rem_ge;
  logic                 frac_end;
  logic [FW+1:0]        r_sh;

  assign fire    = valid_o && ready_i;
  assign r_sh    = {r_q, 1'b0};
  assign rem_sh  = {rem_acc_q, v_q[INT_BITS-1]};
  assign tb_ext  = (INT_BITS+1)'(tgt_base_i);
  assign rem_ge  = rem_sh >= tb_ext;
  assign fm      = (FRAC_BITS+5)'(f_q) * (FRAC_BITS+5)'(tgt_base_i);
  assign frac_end = fm[FRAC_BITS-1:0] <= Eps || k_q == KW'(MAX_FRAC_OUT - 1);
  assign zero_val = v_q == '0 && f_q <= Eps;
  assign wr_buf  = state_q == BK_IDIV && bit_q == QW'(INT_BITS - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (!empty_i) state_d = (err_i || !base_ok(src_base_i) ||
                                         !base_ok(tgt_base_i)) ? BK_ERR : BK_FDIV;
      BK_FDIV:  if (step_q == SW'(FRAC_BITS - 1)) state_d = BK_CHECK;
      BK_CHECK: state_d = zero_val ? BK_IOUT : (neg_q ? BK_SIGN : BK_IDIV);
      BK_SIGN:  if (fire) state_d = BK_IDIV;
      BK_IDIV:  if (v_q == '0 && bit_q == '0) state_d = BK_IOUT;
      BK_IOUT:  if (fire && (nd_q <= IW'(1) || zero_q))
                  state_d = (zero_q || f_q <= Eps) ? BK_IDLE : BK_POINT;
      BK_POINT: if (fire) state_d = BK_FMUL;
      BK_FMUL:  state_d = BK_FOUT;
      BK_FOUT:  if (fire) state_d = frac_end ? BK_IDLE : BK_FMUL;
      BK_ERR:   if (fire) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    valid_o = 1'b0;
    item_o = '0;
    unique case (state_q)
      BK_SIGN: begin valid_o = 1'b1; item_o.out_char = ChMinus; end
      BK_IOUT: begin
        valid_o = 1'b1;
        item_o.out_char = (zero_q || nd_q == '0) ? ChZero : glyph(buf_rd_q);
        item_o.out_last = zero_q || (nd_q <= IW'(1) && f_q <= Eps);
      end
      BK_POINT: begin valid_o = 1'b1; item_o.out_char = ChPoint; end
      BK_FOUT: begin
        valid_o = 1'b1;
        item_o.out_char = glyph(fm[FRAC_BITS+3:FRAC_BITS]);
        item_o.out_last = frac_end;
      end
      BK_ERR: begin valid_o = 1'b1; item_o.out_error = 1'b1; item_o.out_last = 1'b1; end
      default: ;
    endcase
  end

  assign pop_o = state_q == BK_IDLE && !empty_i;

  always_ff @(posedge clk_i) begin
    if (wr_buf) buf_q[nd_q[BW-1:0]] <= rem_ge ? 4'(rem_sh - tb_ext) : 4'(rem_sh);
    if (state_q == BK_IOUT && fire) buf_rd_q <= buf_q[BW'(nd_q - IW'(2))];
    else buf_rd_q <= buf_q[BW'(nd_q - IW'(1))];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      v_q <= '0; quo_q <= '0; rem_acc_q <= '0; r_q <= '0; den_q <= '0;
      f_q <= '0; step_q <= '0; bit_q <= '0; nd_q <= '0; k_q <= '0; neg_q <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        BK_IDLE: if (!empty_i) begin
          v_q <= int_i; r_q <= (FW+1)'(numer_i); den_q <= (FW+1)'(denom_i);
          neg_q <= neg_i; f_q <= '0; step_q <= '0; nd_q <= '0; k_q <= '0;
        end
        BK_FDIV: begin
          step_q <= step_q + 1'b1;
          if (r_sh >= (FW+2)'(den_q)) begin
            r_q <= (FW+1)'(r_sh - (FW+2)'(den_q)); f_q <= {f_q[FRAC_BITS-2:0], 1'b1};
          end else begin
            r_q <= r_sh[FW:0]; f_q <= {f_q[FRAC_BITS-2:0], 1'b0};
          end
        end
        BK_CHECK: begin bit_q <= '0; quo_q <= '0; rem_acc_q <= '0; zero_q <= zero_val; end
        BK_IDIV: begin
          if (v_q != '0 || bit_q != '0) begin
            if (bit_q == QW'(INT_BITS - 1)) begin
              nd_q <= nd_q + 1'b1;
              v_q <= {quo_q[INT_BITS-2:0], rem_ge};
              bit_q <= '0; quo_q <= '0; rem_acc_q <= '0;
            end else begin
              v_q <= {v_q[INT_BITS-2:0], 1'b0};
              rem_acc_q <= rem_ge ? INT_BITS'(rem_sh - tb_ext) : INT_BITS'(rem_sh);
              quo_q <= {quo_q[INT_BITS-2:0], rem_ge};
              bit_q <= bit_q + 1'b1;
            end
          end
        end
        BK_IOUT: if (fire) nd_q <= nd_q - IW'(nd_q != '0);
        BK_FMUL: ;
        BK_FOUT: if (fire) begin
          f_q <= fm[FRAC_BITS-1:0]; k_q <= k_q + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ===== design/radix_converter_signed_fraction.sv =====
// After the last character the back end divides the fraction (BK_FDIV) and checks for a
// zero value; a sign or zero goes out next, else integer digits are divided first (BK_IDIV).
// One character per cycle enters the front while the command queue is not full; while pop
// is held, integer digits leave one per cycle, each fraction digit after a BK_FMUL step.
// Reset: asynchronous, active low; both bases return to 10, numeral state cleared.
module radix_converter_signed_fraction #(
  parameter int unsigned INT_BITS     = 48,
  parameter int unsigned MAX_FRAC_IN  = 12,
  parameter int unsigned FRAC_BITS    = 40,
  parameter int unsigned MAX_FRAC_OUT = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  rcsf_pkg::in_item_t         in_item_i,
  output logic                       empty,
  input  logic                       pop,
  output rcsf_pkg::out_item_t        out_item_o,
  input  logic                       cfg_we_i,
  input  logic [rcsf_pkg::IdxW-1:0]  cfg_idx_i,
  input  logic [rcsf_pkg::BaseW-1:0] cfg_data_i
);
  import rcsf_pkg::*;

  localparam int unsigned FW = 4 * MAX_FRAC_IN + 1;
  localparam int unsigned QW = INT_BITS + 2 * FW + 2;

  logic [BaseW-1:0] src_q, tgt_q;
  logic             q_push, q_full, q_empty, q_pop;
  logic [QW-1:0]    q_in, q_out;
  logic [INT_BITS-1:0] f_int;
  logic [FW-1:0]       f_num, f_den;
  logic                f_neg, f_err;
  logic                r_valid, r_full, r_empty;
  out_item_t           r_item;
  logic [$bits(out_item_t)-1:0] r_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_q <= BaseReset; tgt_q <= BaseReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegSrcBase: src_q <= cfg_data_i;
        RegTgtBase: tgt_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign full = q_full;

  rcsf_front #(.INT_BITS(INT_BITS), .MAX_FRAC_IN(MAX_FRAC_IN)) u_front (
    .clk_i, .rst_ni, .valid_i(push), .item_i(in_item_i), .src_base_i(src_q),
    .full_i(q_full), .push_o(q_push), .int_o(f_int), .numer_o(f_num),
    .denom_o(f_den), .neg_o(f_neg), .err_o(f_err)
  );

  assign q_in = {f_int, f_num, f_den, f_neg, f_err};

  rcsf_queue #(.W(QW)) u_cmdq (
    .clk_i, .rst_ni, .push_i(q_push), .data_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .data_o(q_out), .empty_o(q_empty)
  );

  rcsf_back #(.INT_BITS(INT_BITS), .MAX_FRAC_IN(MAX_FRAC_IN), .FRAC_BITS(FRAC_BITS),
              .MAX_FRAC_OUT(MAX_FRAC_OUT)) u_back (
    .clk_i, .rst_ni, .empty_i(q_empty), .pop_o(q_pop),
    .int_i(q_out[QW-1 -: INT_BITS]), .numer_i(q_out[2*FW+1 -: FW]),
    .denom_i(q_out[FW+1 -: FW]), .neg_i(q_out[1]), .err_i(q_out[0]),
    .src_base_i(src_q), .tgt_base_i(tgt_q),
    .valid_o(r_valid), .item_o(r_item), .ready_i(!r_full)
  );

  rcsf_queue #(.W($bits(out_item_t))) u_resq (
    .clk_i, .rst_ni, .push_i(r_valid), .data_i(r_item), .full_o(r_full),
    .pop_i(pop), .data_o(r_out), .empty_o(r_empty)
  );

  assign empty = r_empty;
  assign out_item_o = r_out;
endmodule

// ===== design/rcsf_checker.sv =====
module rcsf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input rcsf_pkg::out_item_t out_item_o
);
  import rcsf_pkg::*;
  `include "radix_converter_signed_fraction_macros.svh"

  `RCSF_ASSERT_IMP(a_err_last, clk_i, rst_ni, !empty && out_item_o.out_error, out_item_o.out_last && out_item_o.out_char == '0, "error result malformed")
  `RCSF_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(out_item_o), "waiting result changed")
  `RCSF_ASSERT_IMP(a_err_char, clk_i, rst_ni, !empty && !out_item_o.out_error, out_item_o.out_char != '0, "null character on success")
  `RCSF_ASSERT_IMP(a_flags_known, clk_i, rst_ni, 1'b1, !$isunknown({push, full, empty, pop}), "handshake flag unknown")
endmodule

bind radix_converter_signed_fraction rcsf_checker u_rcsf_checker (
  .clk_i, .rst_ni, .push, .full, .empty, .pop, .out_item_o
);
